FILE: sv/sirq_pkg.sv
// ----------------------------------------------------------------------------
// sirq_pkg: shared constants for the sorted interquartile range unit
// Sizes of the sorted store, derived widths and result status codes.
// ----------------------------------------------------------------------------
package sirq_pkg;

  localparam int MAX_VALUES = 16;
  localparam int VALUE_BITS = 16;

  // count holds 0..MAX_VALUES, address holds 0..MAX_VALUES-1
  localparam int CNT_W  = $clog2(MAX_VALUES + 1);
  localparam int ADDR_W = $clog2(MAX_VALUES);
  // doubled-unit accumulator for q3 - q1
  localparam int ACC_W  = VALUE_BITS + 1;

  localparam int SPREAD_W = 16;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 24;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

endpackage

FILE: sv/sirq_ram.sv
// ----------------------------------------------------------------------------
// sirq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sirq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sorted_interquartile_range_unit.sv
// ----------------------------------------------------------------------------
// sorted_interquartile_range_unit: streaming interquartile range of a set
// Values arrive one beat at a time and are kept in ascending order in a small
// RAM by an insertion pass. A beat with tlast closes the set: the unit reads
// the two quartiles of the sorted store and returns one result beat holding
// q3 - q1 (truncated toward zero) and a status code. The store then empties
// for the next set. An insertion moves up every stored value greater than the
// new one (at most MAX_VALUES - 1), comparing one stored entry per cycle
// through the single RAM read port. A beat dropped because the store is full
// skips the insertion. A tlast beat then makes the four quartile reads
// through that same port and one shared add/subtract unit (none for a set of
// fewer than two values), plus any wait for the output register to drain. The
// unit is not ready while it works. A value that arrives with the store full
// is dropped and reported as status 2 at the end of the set; fewer than two
// values give status 1 and spread 0.
// ----------------------------------------------------------------------------
module sorted_interquartile_range_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic        s_tlast,   // last value of the set
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] spread, [17:16] status, [23:18] zero
);

  localparam int CW = sirq_pkg::CNT_W;
  localparam int AW = sirq_pkg::ADDR_W;
  localparam int VB = sirq_pkg::VALUE_BITS;
  localparam int AC = sirq_pkg::ACC_W;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_CMP = 3'd1;  // compare/shift one entry per cycle
  localparam logic [2:0] S_INS_PUT = 3'd2;  // drop the new value at slot 0
  localparam logic [2:0] S_FIN     = 3'd3;  // insert done, route on last
  localparam logic [2:0] S_QRD     = 3'd4;  // four quartile reads + accumulate
  localparam logic [2:0] S_OUT     = 3'd5;  // load output register

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          overflow, overflow_next;
  logic [CW-1:0] pos, pos_next;
  logic [VB-1:0] val, val_next;
  logic          last, last_next;
  logic          short, short_next;
  logic [2:0]    step, step_next;
  logic [AC-1:0] acc, acc_next;

  logic          out_valid_next;
  logic [23:0]   out_data, out_data_next;

  // RAM port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VB-1:0] wdata, rdata;

  // quartile addressing: t = n/2, h = t/2, upper half at t + (n odd)
  logic [CW-1:0] half_t, quart_h, upper, lo_a, q_addr;
  logic [AC-1:0] operand;
  logic [AC-1:0] addsub;
  logic [VB-1:0] spread_full;
  logic [31:0]   spread_wide;
  logic [15:0]   spread;
  logic [1:0]    status;

  sirq_ram #(
    .WIDTH(VB),
    .DEPTH(sirq_pkg::MAX_VALUES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign s_tready = (state == S_IDLE);

  always_comb begin
    half_t  = count >> 1;
    quart_h = half_t >> 1;
    upper   = half_t + CW'(count[0]);
    // odd t: the same middle element twice; even t: the two middle ones
    lo_a    = half_t[0] ? quart_h : quart_h - CW'(1);
    unique case (step)
      3'd0:    q_addr = upper + lo_a;
      3'd1:    q_addr = upper + quart_h;
      3'd2:    q_addr = lo_a;
      default: q_addr = quart_h;
    endcase
  end

  // shared add/subtract: upper quartile reads add, lower ones subtract
  assign operand = AC'(rdata);
  assign addsub  = (step >= 3'd3) ? acc - operand : acc + operand;

  // halve the doubled-unit difference, saturate to the field width
  assign spread_full = acc[VB:1];
  assign spread_wide = 32'(spread_full);
  assign spread      = (spread_wide > 32'h0000_FFFF) ? 16'hFFFF : spread_wide[15:0];
  assign status      = short ? sirq_pkg::ST_SHORT :
                       overflow ? sirq_pkg::ST_DROP : sirq_pkg::ST_OK;

  always_comb begin
    state_next     = state;
    count_next     = count;
    overflow_next  = overflow;
    pos_next       = pos;
    val_next       = val;
    last_next      = last;
    short_next     = short;
    step_next      = step;
    acc_next       = acc;
    out_valid_next = m_tvalid && !m_tready;
    out_data_next  = out_data;
    we             = 1'b0;
    waddr          = pos[AW-1:0];
    wdata          = val;
    raddr          = pos[AW-1:0];

    unique case (state)
      S_IDLE: begin
        // prefetch the top entry so the first compare has it at hand
        raddr = AW'(count - CW'(1));
        if (s_tvalid) begin
          val_next  = VB'(s_tdata);
          last_next = s_tlast;
          pos_next  = count;
          if (count == CW'(sirq_pkg::MAX_VALUES)) begin
            overflow_next = 1'b1;
            state_next    = S_FIN;
          end else if (count == '0) begin
            state_next = S_INS_PUT;
          end else begin
            state_next = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        raddr = AW'(pos - CW'(2));
        we    = 1'b1;
        if (rdata > val) begin
          // move the larger entry up one slot
          wdata    = rdata;
          pos_next = pos - CW'(1);
          if (pos == CW'(1)) begin
            state_next = S_INS_PUT;
          end
        end else begin
          wdata      = val;
          count_next = count + CW'(1);
          state_next = S_FIN;
        end
      end
      S_INS_PUT: begin
        we         = 1'b1;
        count_next = count + CW'(1);
        state_next = S_FIN;
      end
      S_FIN: begin
        acc_next   = '0;
        step_next  = '0;
        short_next = (count < CW'(2));
        if (!last) begin
          state_next = S_IDLE;
        end else if (count < CW'(2)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_QRD;
        end
      end
      S_QRD: begin
        raddr     = q_addr[AW-1:0];
        step_next = step + 3'd1;
        if (step != 3'd0) begin
          acc_next = addsub;
        end
        if (step == 3'd4) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {6'b0, status, short ? 16'h0000 : spread};
          count_next     = '0;
          overflow_next  = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // step counts reads issued; the adder works on the registered data of the read before,
  // so step 1..2 add upper entries and step 3..4 subtract lower ones

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
      m_tvalid <= out_valid_next;
    end
    pos      <= pos_next;
    val      <= val_next;
    last     <= last_next;
    short    <= short_next;
    step     <= step_next;
    acc      <= acc_next;
    out_data <= out_data_next;
  end

  assign m_tdata = out_data;

endmodule

FILE: sv/sirq_checker.sv
// ----------------------------------------------------------------------------
// sirq_checker: port-level checks for the interquartile range unit
// Watches the two stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module sirq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // every accepted beat leaves the unit not ready in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // status is one of the defined codes and padding is zero
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:18] == 6'd0) &&
                 (m_tdata[17:16] == sirq_pkg::ST_OK ||
                  m_tdata[17:16] == sirq_pkg::ST_SHORT ||
                  m_tdata[17:16] == sirq_pkg::ST_DROP))
    else $error("bad status or padding");

  // a short set reports no spread
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] == sirq_pkg::ST_SHORT |-> m_tdata[15:0] == 16'd0)
    else $error("short set with nonzero spread");

  // a result is never raised by accepting a non-last beat while none is pending
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result without a closing beat");

endmodule

bind sorted_interquartile_range_unit sirq_checker u_sirq_checker (.*);
